/* rtl/core/rjlm_pkg.sv */
// ---------------------------------------------------------------------------
// rjlm_pkg
// Shared constants, codes and types of the link monitor.
// ---------------------------------------------------------------------------
package rjlm_pkg;

  localparam int NUM_CLIENTS   = 16;
  localparam int PENDING_DEPTH = 16;
  localparam int WINDOW_MAX    = 64;

  localparam int CW = $clog2(NUM_CLIENTS);
  localparam int PW = $clog2(PENDING_DEPTH);
  localparam int RW = $clog2(WINDOW_MAX);
  localparam int NW = $clog2(WINDOW_MAX + 1);

  localparam logic [2:0] REQ_SENT  = 3'd0;
  localparam logic [2:0] REQ_RECV  = 3'd1;
  localparam logic [2:0] REQ_ACK   = 3'd2;
  localparam logic [2:0] REQ_LOSS  = 3'd3;

  typedef struct packed {
    logic [31:0] sent;
    logic [31:0] recv;
    logic [31:0] lost;
    logic [47:0] sbytes;
    logic [47:0] rbytes;
  } cnt_t;

  typedef struct packed {
    logic [RW-1:0] head;
    logic [NW-1:0] count;
    logic [37:0]   rsum;
    logic [37:0]   dsum;
  } ring_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [37:0] den;
  } div_req_t;

  function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [RW-1:0] wrap_add(input logic [RW-1:0] a, input logic [NW-1:0] b);
    logic [NW:0] s;
    s = {{(NW + 1 - RW){1'b0}}, a} + {1'b0, b};
    if (s >= (NW + 1)'(WINDOW_MAX)) s = s - (NW + 1)'(WINDOW_MAX);
    wrap_add = s[RW-1:0];
  endfunction

endpackage

/* rtl/core/rjlm_div.sv */
// ---------------------------------------------------------------------------
// rjlm_div
// Restoring divider, one quotient bit a cycle; zero divisor gives zero.
// ---------------------------------------------------------------------------
module rjlm_div
  import rjlm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] num;
  logic [37:0] den;
  logic [38:0] rem;
  logic [6:0]  cnt;
  logic        run;
  logic [38:0] trial;

  assign trial = {rem[37:0], num[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= (req.den != '0);
        done <= (req.den == '0);
        num <= req.num;
        den <= req.den;
        rem <= '0;
        quo <= '0;
        cnt <= 7'd0;
      end else if (run) begin
        num <= {num[62:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/rtt_jitter_loss_monitor.sv */
// ---------------------------------------------------------------------------
// rtt_jitter_loss_monitor
// Per-client RTT, jitter and packet loss monitor.
// ---------------------------------------------------------------------------
// Usage: drive the request fields with start high while busy is low; the
// request is taken at that edge. The result appears on the result ports for
// one cycle with result_valid high; the receiver cannot stall it.
// window_size is written through cfg_valid/cfg_ready; cfg_ready is high only
// while the block is idle and no request is being taken.
// A received or query request goes from accept to result through the memory
// read states S_RD and S_LD, a write-back, three quotients one after another
// through one 64-step serial divider (a zero divisor skips the steps) and an
// output state. Sent, ack and loss also scan the pending table one entry a
// cycle through its memory port; a matched ack also updates the ring.
// One request is in flight at a time; busy stays high until its result.
// At reset a clearing pass over every client zeroes the counter and ring
// control memories; busy is high during it. Client indexes beyond the table
// return all-zero results.
// ---------------------------------------------------------------------------
module rtt_jitter_loss_monitor
  import rjlm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [3:0]  client,
  input  logic [31:0] sequence_req,
  input  logic [15:0] byte_count,
  input  logic [31:0] timestamp_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        result_valid,
  output logic [31:0] sent_count,
  output logic [31:0] received_count,
  output logic [31:0] lost_count,
  output logic [47:0] sent_bytes,
  output logic [47:0] received_bytes,
  output logic [31:0] mean_rtt_us,
  output logic [31:0] jitter_us,
  output logic [14:0] loss_percent_q8,
  output logic [6:0]  sample_count,
  output logic        ack_matched
);

  typedef enum logic [16:0] {
    S_CLR   = 17'd1,
    S_IDLE  = 17'd2,
    S_RD    = 17'd4,
    S_LD    = 17'd8,
    S_SCAN  = 17'd16,
    S_PEND  = 17'd32,
    S_ROLD  = 17'd64,
    S_RNXT  = 17'd128,
    S_RLAST = 17'd256,
    S_WAITR = 17'd512,
    S_PUSH  = 17'd1024,
    S_WB    = 17'd2048,
    S_DIV0  = 17'd4096,
    S_DIV1  = 17'd8192,
    S_DIV2  = 17'd16384,
    S_DIVW  = 17'd32768,
    S_OUT   = 17'd65536
  } state_t;

  state_t state;
  logic [6:0] window_size;
  logic [2:0] rtype;
  logic [CW-1:0] cl;
  logic [31:0] seq, now;
  logic [15:0] bytes;
  logic        bad;

  cnt_t  cnt_mem [NUM_CLIENTS];
  ring_t ring_mem [NUM_CLIENTS];
  logic [63:0] pend_mem [NUM_CLIENTS*PENDING_DEPTH];
  logic [31:0] rtt_mem [NUM_CLIENTS*WINDOW_MAX];
  logic [PENDING_DEPTH-1:0] pvalid [NUM_CLIENTS];

  cnt_t  cnt_rd, cnt;
  ring_t ring_rd, ring;
  logic [63:0] pend_rd;
  logic [31:0] rtt_rd;

  logic [CW-1:0] clr_idx;
  logic [PW:0]   scan_idx;
  logic [PW-1:0] hit_idx, free_idx, old_idx;
  logic          hit, free_found, scan_first;
  logic [31:0]   best_age, hit_ts;
  logic [31:0]   old_s, rtt_s;
  logic          matched;
  logic [1:0]    div_sel;
  logic [6:0]    win;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquo;

  logic [PW+CW-1:0] pend_addr;
  logic [RW+CW-1:0] rtt_addr;
  logic             pend_we, rtt_we;
  logic [63:0]      pend_wd;
  logic [31:0]      rtt_wd;

  logic [32:0] tot;
  logic [63:0] lost_scaled;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign win = (window_size == 7'd0) ? 7'd1 :
               (window_size > 7'(WINDOW_MAX)) ? 7'(WINDOW_MAX) : window_size;
  assign tot = {1'b0, cnt.sent} + {1'b0, cnt.lost};
  assign lost_scaled = 64'(cnt.lost) * 64'd25600;

  rjlm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_addr] <= pend_wd;
    pend_rd <= pend_mem[pend_addr];
    if (rtt_we) rtt_mem[rtt_addr] <= rtt_wd;
    rtt_rd <= rtt_mem[rtt_addr];
    cnt_rd  <= cnt_mem[cl];
    ring_rd <= ring_mem[cl];
    if (state == S_CLR) begin
      cnt_mem[clr_idx]  <= '0;
      ring_mem[clr_idx] <= '0;
    end else if (state == S_WB) begin
      cnt_mem[cl]  <= cnt;
      ring_mem[cl] <= ring;
    end
  end

  always_comb begin
    pend_addr = {cl, scan_idx[PW-1:0]};
    pend_we   = 1'b0;
    pend_wd   = {seq, now};
    rtt_addr  = {cl, ring.head};
    rtt_we    = 1'b0;
    rtt_wd    = rtt_s;
    unique case (state)
      S_PEND: begin
        pend_addr = {cl, hit ? hit_idx : (free_found ? free_idx : old_idx)};
        pend_we   = (rtype == REQ_SENT);
      end
      S_ROLD:  rtt_addr = {cl, ring.head};
      S_RNXT:  rtt_addr = {cl, wrap_add(ring.head, NW'(1))};
      S_RLAST: rtt_addr = {cl, wrap_add(ring.head, ring.count - NW'(1))};
      S_PUSH: begin
        rtt_addr = {cl, wrap_add(ring.head, ring.count)};
        rtt_we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    result_valid <= 1'b0;
    if (rst) begin
      state       <= S_CLR;
      clr_idx     <= '0;
      window_size <= 7'd64;
      for (int i = 0; i < NUM_CLIENTS; i++) pvalid[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) window_size <= cfg_data;
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + CW'(1);
          if (clr_idx == CW'(NUM_CLIENTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          rtype   <= req_type;
          cl      <= client[CW-1:0];
          bad     <= (5'(client) >= 5'(NUM_CLIENTS));
          seq     <= sequence_req;
          now     <= timestamp_us;
          bytes   <= byte_count;
          matched <= 1'b0;
          state   <= S_RD;
        end
        S_RD: state <= S_LD;
        S_LD: begin
          cnt  <= cnt_rd;
          ring <= ring_rd;
          scan_idx   <= '0;
          hit        <= 1'b0;
          free_found <= 1'b0;
          scan_first <= 1'b1;
          if (bad) state <= S_OUT;
          else if (rtype == REQ_SENT || rtype == REQ_ACK || rtype == REQ_LOSS)
            state <= S_SCAN;
          else begin
            if (rtype == REQ_RECV) begin
              cnt.recv   <= cnt_rd.recv + 32'd1;
              cnt.rbytes <= cnt_rd.rbytes + 48'(bytes);
            end
            state <= S_WB;
          end
        end
        S_SCAN: begin
          // pend_rd holds entry scan_idx-1 once scan_idx > 0
          if (scan_idx != '0) begin
            logic [PW-1:0] k;
            logic [31:0] age;
            k = PW'(scan_idx - 1'b1);
            age = now - pend_rd[31:0];
            if (pvalid[cl][k]) begin
              if (!hit && pend_rd[63:32] == seq) begin
                hit <= 1'b1; hit_idx <= k; hit_ts <= pend_rd[31:0];
              end
            end else if (!free_found) begin
              free_found <= 1'b1; free_idx <= k;
            end
            if (scan_first || age > best_age) begin
              best_age <= age; old_idx <= k;
            end
            scan_first <= 1'b0;
          end
          if (scan_idx == (PW+1)'(PENDING_DEPTH)) state <= S_PEND;
          else scan_idx <= scan_idx + 1'b1;
        end
        S_PEND: begin
          state <= S_WB;
          if (rtype == REQ_SENT) begin
            cnt.sent   <= cnt.sent + 32'd1;
            cnt.sbytes <= cnt.sbytes + 48'(bytes);
            pvalid[cl][hit ? hit_idx : (free_found ? free_idx : old_idx)] <= 1'b1;
          end else if (rtype == REQ_LOSS) begin
            cnt.lost <= cnt.lost + 32'd1;
            if (hit) pvalid[cl][hit_idx] <= 1'b0;
          end else if (hit) begin
            pvalid[cl][hit_idx] <= 1'b0;
            matched <= 1'b1;
            rtt_s   <= now - hit_ts;
            if (7'(ring.count) >= win && ring.count != '0) state <= S_ROLD;
            else if (ring.count != '0) state <= S_RLAST;
            else state <= S_PUSH;
          end
        end
        S_ROLD: state <= S_RNXT;
        S_RNXT: begin
          old_s <= rtt_rd;
          state <= S_WAITR;
          div_sel <= 2'd0;
        end
        S_WAITR: begin
          if (div_sel == 2'd0) begin
            // rtt_rd now holds the next sample
            if (ring.count >= NW'(2)) ring.dsum <= ring.dsum - 38'(absdiff(old_s, rtt_rd));
            ring.rsum  <= ring.rsum - 38'(old_s);
            ring.head  <= wrap_add(ring.head, NW'(1));
            ring.count <= ring.count - NW'(1);
            div_sel <= 2'd1;
          end else if (div_sel == 2'd1) begin
            state <= (ring.count != '0) ? S_RLAST : S_PUSH;
          end else begin
            ring.dsum <= ring.dsum + 38'(absdiff(rtt_rd, rtt_s));
            state <= S_PUSH;
          end
        end
        S_RLAST: begin
          div_sel <= 2'd2;
          state   <= S_WAITR;
        end
        S_PUSH: begin
          ring.rsum  <= ring.rsum + 38'(rtt_s);
          ring.count <= ring.count + NW'(1);
          state <= S_WB;
        end
        S_WB: begin
          dreq.start <= 1'b1;
          dreq.num   <= 64'(ring.rsum);
          dreq.den   <= 38'(ring.count);
          state <= S_DIV0;
        end
        S_DIV0: if (ddone) begin
          mean_rtt_us <= dquo[31:0];
          dreq.start <= 1'b1;
          dreq.num   <= 64'(ring.dsum);
          dreq.den   <= (ring.count >= NW'(2)) ? 38'(ring.count - NW'(1)) : '0;
          state <= S_DIV1;
        end
        S_DIV1: if (ddone) begin
          jitter_us  <= dquo[31:0];
          dreq.start <= 1'b1;
          dreq.num   <= lost_scaled;
          dreq.den   <= 38'(tot);
          state <= S_DIV2;
        end
        S_DIV2: if (ddone) begin
          loss_percent_q8 <= dquo[14:0];
          state <= S_OUT;
        end
        S_DIVW: state <= S_OUT;
        S_OUT: begin
          result_valid   <= 1'b1;
          sent_count     <= bad ? '0 : cnt.sent;
          received_count <= bad ? '0 : cnt.recv;
          lost_count     <= bad ? '0 : cnt.lost;
          sent_bytes     <= bad ? '0 : cnt.sbytes;
          received_bytes <= bad ? '0 : cnt.rbytes;
          sample_count   <= bad ? '0 : 7'(ring.count);
          ack_matched    <= matched && !bad;
          if (bad) begin
            mean_rtt_us <= '0; jitter_us <= '0; loss_percent_q8 <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/rjlm_checker.sv */
// ---------------------------------------------------------------------------
// rjlm_checker
// Port-level checks of the link monitor, bound to the top level.
// ---------------------------------------------------------------------------
module rjlm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [6:0]  sample_count,
  input logic [14:0] loss_percent_q8,
  input logic        ack_matched
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not held busy");

  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without request");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_count <= 7'd64) else $error("sample count range");

  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> loss_percent_q8 <= 15'd25600) else $error("loss range");

  a_match_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && ack_matched |-> sample_count != 7'd0) else $error("match no sample");

endmodule

bind rtt_jitter_loss_monitor rjlm_checker u_rjlm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid),
  .sample_count(sample_count), .loss_percent_q8(loss_percent_q8),
  .ack_matched(ack_matched)
);
